[sv/glzw_pkg.sv]
package glzw_pkg;

	localparam logic [1:0] OP_PUSH    = 2'd0;
	localparam logic [1:0] OP_PULL    = 2'd1;
	localparam logic [1:0] OP_RESTART = 2'd2;

	localparam logic [2:0] ST_PIXEL  = 3'd0;
	localparam logic [2:0] ST_ACCEPT = 3'd1;
	localparam logic [2:0] ST_END    = 3'd2;
	localparam logic [2:0] ST_NODATA = 3'd3;
	localparam logic [2:0] ST_BAD    = 3'd4;
	localparam logic [2:0] ST_FULL   = 3'd5;

	localparam logic [1:0] FIN_RUN = 2'd0;
	localparam logic [1:0] FIN_END = 2'd1;
	localparam logic [1:0] FIN_BAD = 2'd2;

	localparam int HOLDER_BITS = 24;
	localparam logic [3:0] SIZE_MIN   = 4'd2;
	localparam logic [3:0] SIZE_MAX   = 4'd8;
	localparam logic [3:0] SIZE_RESET = 4'd8;

	typedef enum logic [3:0] {
		S_IDLE,
		S_DISP,
		S_FETCH,
		S_LOAD,
		S_CODE,
		S_UNW_RD,
		S_UNW_WR,
		S_FIXK,
		S_UPD,
		S_POP,
		S_DONE
	} glzw_state_t;

	typedef struct packed {
		logic accept;
		logic push_byte;
		logic restart;
		logic fetch_rd;
		logic load;
		logic extract;
		logic do_clear;
		logic set_end;
		logic set_bad;
		logic push_lit;
		logic unw_start;
		logic unw_rd;
		logic unw_wr;
		logic unw_last;
		logic fixk;
		logic upd;
		logic pop_rd;
	} glzw_cmd_t;

	typedef struct packed {
		logic       store_full;
		logic       store_empty;
		logic       have_bits;
		logic       code_clear;
		logic       code_end;
		logic       prev_clear;
		logic       code_ge_lit;
		logic       code_bad;
		logic       c_phrase;
		logic       kwk;
		logic       stack_nonempty;
		logic [1:0] fin;
		logic [7:0] stack_rd;
	} glzw_stat_t;

endpackage

[sv/glzw_dp.sv]
module glzw_dp #(
	parameter int DICT_ENTRIES  = 4096,
	parameter int MAX_CODE_BITS = 12,
	parameter int STORE_DEPTH   = 1024
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic [3:0]         min_code_size,
	input  logic [7:0]         data_byte,
	input  glzw_pkg::glzw_cmd_t cmd,
	output glzw_pkg::glzw_stat_t stat
);
	import glzw_pkg::*;

	localparam int DW = $clog2(DICT_ENTRIES);
	localparam int CW = MAX_CODE_BITS;
	localparam int NW = CW + 1;
	localparam int SW = $clog2(STORE_DEPTH);
	localparam int PW = SW + 1;
	localparam int TLIM = (DICT_ENTRIES < (1 << CW)) ? DICT_ENTRIES : (1 << CW);
	localparam logic [PW:0]   PWRAP   = (PW + 1)'(2 * STORE_DEPTH);
	localparam logic [PW-1:0] PLAST   = PW'(2 * STORE_DEPTH - 1);
	localparam logic [PW-1:0] DEPTH_P = PW'(STORE_DEPTH);
	localparam logic [DW:0]   SDEPTH  = (DW + 1)'(DICT_ENTRIES);
	localparam logic [NW-1:0] TLIM_N  = NW'(TLIM);

	logic [7:0]    byte_store [STORE_DEPTH];
	logic [CW-1:0] prefix_table [DICT_ENTRIES];
	logic [7:0]    suffix_table [DICT_ENTRIES];
	logic [7:0]    phrase_stack [DICT_ENTRIES];

	logic [PW-1:0] head_q, tail_q;
	logic [7:0]    data_q, store_rd_q, suf_rd_q, stack_rd_q, k_q;
	logic [CW-1:0] pre_rd_q, code_q, c_q, prev_q;
	logic [HOLDER_BITS-1:0] holder_q;
	logic [4:0]    bits_q;
	logic [3:0]    width_q, active_q;
	logic [NW-1:0] nfc_q;
	logic [1:0]    fin_q;
	logic [DW:0]   count_q;
	logic          kwk_q;

	logic [PW:0]   used;
	logic [SW-1:0] head_slot, tail_slot;
	logic [NW-1:0] lit, lit_s;
	logic [3:0]    size_s;
	logic          st_we;
	logic [DW-1:0] st_wa;
	logic [7:0]    st_wd;
	logic [DW-1:0] pop_idx;

	function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
		return (p == PLAST) ? '0 : p + 1'b1;
	endfunction

	function automatic logic [SW-1:0] ptr_slot(input logic [PW-1:0] p);
		return (p >= DEPTH_P) ? SW'(p - DEPTH_P) : SW'(p);
	endfunction

	always_comb begin
		if (tail_q >= head_q) begin
			used = {1'b0, tail_q} - {1'b0, head_q};
		end else begin
			used = {1'b0, tail_q} + PWRAP - {1'b0, head_q};
		end
		head_slot = ptr_slot(head_q);
		tail_slot = ptr_slot(tail_q);
		lit = NW'(1) << active_q;
		if (min_code_size < SIZE_MIN) begin
			size_s = SIZE_MIN;
		end else if (min_code_size > SIZE_MAX) begin
			size_s = SIZE_MAX;
		end else begin
			size_s = min_code_size;
		end
		lit_s = NW'(1) << size_s;
		pop_idx = DW'(count_q - 1'b1);
	end

	always_comb begin
		stat.store_full     = used >= {1'b0, DEPTH_P};
		stat.store_empty    = head_q == tail_q;
		stat.have_bits      = bits_q >= {1'b0, width_q};
		stat.code_clear     = {1'b0, code_q} == lit;
		stat.code_end       = {1'b0, code_q} == lit + 1'b1;
		stat.prev_clear     = {1'b0, prev_q} == lit;
		stat.code_ge_lit    = {1'b0, code_q} >= lit;
		stat.code_bad       = ({1'b0, code_q} > nfc_q) || (nfc_q >= TLIM_N);
		stat.c_phrase       = {1'b0, c_q} >= lit + NW'(2);
		stat.kwk            = kwk_q;
		stat.stack_nonempty = count_q != '0;
		stat.fin            = fin_q;
		stat.stack_rd       = stack_rd_q;
	end

	// stack write port: pushes go to the top, the reserved first slot is patched last
	always_comb begin
		st_we = cmd.fixk;
		st_wa = '0;
		st_wd = k_q;
		if (!cmd.fixk && count_q < SDEPTH) begin
			st_wa = count_q[DW-1:0];
			if (cmd.push_lit) begin
				st_we = 1'b1;
				st_wd = code_q[7:0];
			end else if (cmd.unw_wr) begin
				st_we = 1'b1;
				st_wd = suf_rd_q;
			end else if (cmd.unw_last) begin
				st_we = 1'b1;
				st_wd = c_q[7:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.push_byte) begin
			byte_store[tail_slot] <= data_q;
		end
		if (cmd.fetch_rd) begin
			store_rd_q <= byte_store[head_slot];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.upd) begin
			prefix_table[DW'(nfc_q)] <= prev_q;
			suffix_table[DW'(nfc_q)] <= k_q;
		end
		if (cmd.unw_rd) begin
			pre_rd_q <= prefix_table[DW'(c_q)];
			suf_rd_q <= suffix_table[DW'(c_q)];
		end
	end

	always_ff @(posedge clk) begin
		if (st_we) begin
			phrase_stack[st_wa] <= st_wd;
		end
		if (cmd.pop_rd) begin
			stack_rd_q <= phrase_stack[pop_idx];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			data_q <= data_byte;
		end
		if (cmd.extract) begin
			code_q <= CW'(holder_q & ((HOLDER_BITS'(1) << width_q) - 1'b1));
		end
		if (cmd.unw_last) begin
			k_q <= c_q[7:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q   <= '0;
			tail_q   <= '0;
			holder_q <= '0;
			bits_q   <= '0;
			active_q <= SIZE_RESET;
			width_q  <= SIZE_RESET + 4'd1;
			nfc_q    <= (NW'(1) << SIZE_RESET) + NW'(2);
			prev_q   <= CW'(NW'(1) << SIZE_RESET);
			fin_q    <= FIN_RUN;
			count_q  <= '0;
			c_q      <= '0;
			kwk_q    <= 1'b0;
		end else begin
			if (cmd.push_byte) begin
				tail_q <= ptr_inc(tail_q);
			end
			if (cmd.fetch_rd) begin
				head_q <= ptr_inc(head_q);
			end
			if (cmd.load) begin
				holder_q <= holder_q | (HOLDER_BITS'(store_rd_q) << bits_q);
				bits_q   <= bits_q + 5'd8;
			end
			if (cmd.extract) begin
				holder_q <= holder_q >> width_q;
				bits_q   <= bits_q - {1'b0, width_q};
			end
			if (cmd.do_clear) begin
				width_q <= active_q + 4'd1;
				nfc_q   <= lit + NW'(2);
				prev_q  <= CW'(lit);
			end
			if (cmd.set_end) begin
				fin_q <= FIN_END;
			end
			if (cmd.set_bad) begin
				fin_q <= FIN_BAD;
			end
			if (cmd.push_lit) begin
				prev_q  <= code_q;
				count_q <= count_q + 1'b1;
			end
			if (cmd.unw_start) begin
				kwk_q   <= {1'b0, code_q} == nfc_q;
				c_q     <= ({1'b0, code_q} == nfc_q) ? prev_q : code_q;
				count_q <= ({1'b0, code_q} == nfc_q) ? (DW + 1)'(1) : '0;
			end
			if ((cmd.unw_wr || cmd.unw_last) && count_q < SDEPTH) begin
				count_q <= count_q + 1'b1;
			end
			if (cmd.unw_wr) begin
				c_q <= pre_rd_q;
			end
			if (cmd.upd) begin
				nfc_q  <= nfc_q + 1'b1;
				prev_q <= code_q;
				if ((nfc_q + 1'b1) == (NW'(1) << width_q) && width_q < 4'(CW)) begin
					width_q <= width_q + 4'd1;
				end
			end
			if (cmd.pop_rd) begin
				count_q <= count_q - 1'b1;
			end
			if (cmd.restart) begin
				active_q <= size_s;
				count_q  <= '0;
				holder_q <= '0;
				bits_q   <= '0;
				width_q  <= size_s + 4'd1;
				nfc_q    <= lit_s + NW'(2);
				prev_q   <= CW'(lit_s);
				fin_q    <= FIN_RUN;
			end
		end
	end

endmodule

[sv/glzw_ctrl.sv]
module glzw_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [1:0]           op,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [7:0]           pixel_byte,
	output logic [2:0]           status,
	input  glzw_pkg::glzw_stat_t stat,
	output glzw_pkg::glzw_cmd_t  cmd
);
	import glzw_pkg::*;

	glzw_state_t state_q, state_d;
	logic [1:0]  op_q;
	logic [2:0]  res_q, res_d;
	logic        out_valid_q;
	logic [7:0]  pixel_q;
	logic [2:0]  status_q;
	logic        out_free;

	assign out_free   = !out_valid_q || out_ready;
	assign in_ready   = state_q == S_IDLE;
	assign out_valid  = out_valid_q;
	assign pixel_byte = pixel_q;
	assign status     = status_q;

	always_comb begin
		state_d = state_q;
		res_d   = res_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid) state_d = S_DISP;
			end
			S_DISP: begin
				state_d = S_DONE;
				res_d   = ST_ACCEPT;
				case (op_q)
					OP_PUSH: begin
						if (stat.store_full) res_d = ST_FULL;
					end
					OP_PULL: begin
						if (stat.stack_nonempty) begin
							state_d = S_POP;
						end else if (stat.fin == FIN_END) begin
							res_d = ST_END;
						end else if (stat.fin == FIN_BAD) begin
							res_d = ST_BAD;
						end else begin
							state_d = S_FETCH;
						end
					end
					default: ;
				endcase
			end
			S_FETCH: begin
				if (stat.have_bits) begin
					state_d = S_CODE;
				end else if (!stat.store_empty) begin
					state_d = S_LOAD;
				end else begin
					state_d = S_DONE;
					res_d   = ST_NODATA;
				end
			end
			S_LOAD: state_d = S_FETCH;
			S_CODE: begin
				if (stat.code_clear) begin
					state_d = S_FETCH;
				end else if (stat.code_end) begin
					state_d = S_DONE;
					res_d   = ST_END;
				end else if (stat.prev_clear) begin
					if (stat.code_ge_lit) begin
						state_d = S_DONE;
						res_d   = ST_BAD;
					end else begin
						state_d = S_POP;
					end
				end else if (stat.code_bad) begin
					state_d = S_DONE;
					res_d   = ST_BAD;
				end else begin
					state_d = S_UNW_RD;
				end
			end
			S_UNW_RD: begin
				if (stat.c_phrase) begin
					state_d = S_UNW_WR;
				end else if (stat.kwk) begin
					state_d = S_FIXK;
				end else begin
					state_d = S_UPD;
				end
			end
			S_UNW_WR: state_d = S_UNW_RD;
			S_FIXK:   state_d = S_UPD;
			S_UPD:    state_d = S_POP;
			S_POP: begin
				state_d = S_DONE;
				res_d   = ST_PIXEL;
			end
			S_DONE: begin
				if (out_free) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		case (state_q)
			S_IDLE: cmd.accept = in_valid;
			S_DISP: begin
				cmd.push_byte = (op_q == OP_PUSH) && !stat.store_full;
				cmd.restart   = op_q == OP_RESTART;
			end
			S_FETCH: begin
				cmd.extract  = stat.have_bits;
				cmd.fetch_rd = !stat.have_bits && !stat.store_empty;
			end
			S_LOAD: cmd.load = 1'b1;
			S_CODE: begin
				cmd.do_clear = stat.code_clear;
				cmd.set_end  = !stat.code_clear && stat.code_end;
				if (!stat.code_clear && !stat.code_end) begin
					if (stat.prev_clear) begin
						cmd.set_bad  = stat.code_ge_lit;
						cmd.push_lit = !stat.code_ge_lit;
					end else begin
						cmd.set_bad   = stat.code_bad;
						cmd.unw_start = !stat.code_bad;
					end
				end
			end
			S_UNW_RD: begin
				cmd.unw_rd   = stat.c_phrase;
				cmd.unw_last = !stat.c_phrase;
			end
			S_UNW_WR: cmd.unw_wr = 1'b1;
			S_FIXK:   cmd.fixk   = 1'b1;
			S_UPD:    cmd.upd    = 1'b1;
			S_POP:    cmd.pop_rd = 1'b1;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			op_q        <= OP_PUSH;
			res_q       <= ST_ACCEPT;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			res_q   <= res_d;
			if (in_valid && in_ready) begin
				op_q <= op;
			end
			if (state_q == S_DONE && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_DONE && out_free) begin
			status_q <= res_q;
			pixel_q  <= (res_q == ST_PIXEL) ? stat.stack_rd : 8'd0;
		end
	end

	a_accept_disp: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> state_q == S_DISP)
		else $error("accepted request did not dispatch");

	a_unw_order: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_UNW_WR) |-> $past(state_q) == S_UNW_RD)
		else $error("table data used without a read");

	a_pixel_pop: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DONE && res_q == ST_PIXEL && $past(state_q) != S_DONE)
		|-> $past(state_q) == S_POP)
		else $error("pixel result without a stack pop");

endmodule

[sv/gif_lzw_decoder_core.sv]
// channel   | handshake              | payload
// request   | in_valid / in_ready    | op, data_byte
// result    | out_valid / out_ready  | pixel_byte, status
// config    | psel penable pwrite    | paddr, pwdata, prdata (min_code_size at 0 to 3)
//
// push and restart go dispatch to done; a pull served from the stack pops first
// a decoding pull runs fetch and load per store byte read, fetch and code per clear code
// and a read and a write per prefix chain entry, set by the single table read port
// reset leaves an empty store and a decoder at min code size 8; no clearing pass
// a stalled result holds in the output register, one more request is taken and
// waits in the done state until it drains
module gif_lzw_decoder_core #(
	parameter int DICT_ENTRIES  = 4096,
	parameter int MAX_CODE_BITS = 12,
	parameter int STORE_DEPTH   = 1024
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  op,
	input  logic [7:0]  data_byte,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [7:0]  pixel_byte,
	output logic [2:0]  status,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	import glzw_pkg::*;

	logic [3:0] min_size_q;
	glzw_cmd_t  cmd;
	glzw_stat_t stat;

	assign pready = 1'b1;
	assign prdata = paddr[2] ? 32'd0 : {28'd0, min_size_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_size_q <= SIZE_RESET;
		end else if (psel && penable && pwrite && pready && !paddr[2]) begin
			min_size_q <= pwdata[3:0];
		end
	end

	glzw_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.op         (op),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.pixel_byte (pixel_byte),
		.status     (status),
		.stat       (stat),
		.cmd        (cmd)
	);

	glzw_dp #(
		.DICT_ENTRIES  (DICT_ENTRIES),
		.MAX_CODE_BITS (MAX_CODE_BITS),
		.STORE_DEPTH   (STORE_DEPTH)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.min_code_size (min_size_q),
		.data_byte     (data_byte),
		.cmd           (cmd),
		.stat          (stat)
	);

endmodule
